[hw/rtl/assert_macros.svh]
// Assertion macros shared by the reorder window RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PRW_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define PRW_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hw/rtl/prw_pkg.sv]
// Package with command codes, control structs and state encoding of the reorder window.
`timescale 1ns / 1ps
package prw_pkg;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_GET   = 2'd1;
  localparam logic [1:0] CMD_SLIDE = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned LOST_W = 32;
  localparam int unsigned TMO_W  = 16;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd100;

  typedef struct packed {
    logic load_in;
    logic mod_start;
    logic mod_step;
    logic add_wr;
    logic rd_rs;
    logic scan_first;
    logic scan_step;
    logic take;
    logic slide;
    logic empty_get;
    logic load_out;
  } prw_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       mod_last;
    logic       slot_hit;
    logic       held_zero;
    logic       scan_hit;
    logic       scan_last;
    logic       out_free;
  } prw_stat_t;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DISPATCH = 7'b0000010,
    ST_MOD      = 7'b0000100,
    ST_ADD_WR   = 7'b0001000,
    ST_GET_CHK  = 7'b0010000,
    ST_SCAN     = 7'b0100000,
    ST_DONE     = 7'b1000000
  } prw_state_t;

endpackage

[hw/rtl/prw_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module prw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/prw_ctrl.sv]
// Controller state machine sequencing add, get and slide requests.
`timescale 1ns / 1ps
module prw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  prw_pkg::prw_stat_t stat,
  output prw_pkg::prw_cmd_t  cmd
);
  import prw_pkg::*;

  prw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (stat.cmd)
          CMD_ADD: begin
            cmd.mod_start = 1'b1;
            state_nxt     = ST_MOD;
          end
          CMD_GET: begin
            cmd.rd_rs = 1'b1;
            state_nxt = ST_GET_CHK;
          end
          CMD_SLIDE: begin
            cmd.slide = 1'b1;
            state_nxt = ST_DONE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_GET_CHK: begin
        if (stat.slot_hit) begin
          cmd.take  = 1'b1;
          state_nxt = ST_DONE;
        end else if (stat.held_zero) begin
          cmd.empty_get = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          cmd.scan_first = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_hit) begin
          cmd.take  = 1'b1;
          state_nxt = ST_DONE;
        end else if (stat.scan_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/prw_datapath.sv]
// Datapath: slot store, index reduction, timeout scan, counters and result register.
`timescale 1ns / 1ps
module prw_datapath #(
  parameter int unsigned WINDOW_SLOTS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  prw_pkg::prw_cmd_t                 cmd,
  output prw_pkg::prw_stat_t                stat,
  input  logic                              cfg_wr_en,
  input  logic [prw_pkg::TMO_W-1:0]         cfg_wr_data,
  input  logic [1:0]                        in_command,
  input  logic [prw_pkg::SEQ_W-1:0]         in_seq_number,
  input  logic [prw_pkg::TAG_W-1:0]         in_packet_tag,
  input  logic [prw_pkg::TIME_W-1:0]        in_arrival_time,
  input  logic [prw_pkg::TIME_W-1:0]        in_now_time,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_delivered,
  output logic [prw_pkg::TAG_W-1:0]         out_tag,
  output logic [prw_pkg::SEQ_W-1:0]         out_seq,
  output logic [prw_pkg::LOST_W-1:0]        out_lost_total,
  output logic [$clog2(WINDOW_SLOTS+1)-1:0] out_stored_count
);
  import prw_pkg::*;

  localparam int unsigned IW  = $clog2(WINDOW_SLOTS);
  localparam int unsigned RW  = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned DW  = TIME_W + SEQ_W + TAG_W;
  localparam int unsigned XW  = SEQ_W + 1;
  localparam int unsigned SH  = XW + IW;
  localparam int unsigned MW  = XW + 2;
  localparam longint unsigned MUL =
    ((64'd1 << SH) + 64'(WINDOW_SLOTS) - 64'd1) / 64'(WINDOW_SLOTS);
  localparam longint unsigned WRAP =
    ((64'd1 << TIME_W) - (64'd1 << SEQ_W)) % 64'(WINDOW_SLOTS);

  logic [TMO_W-1:0]        timeout_r;
  logic [1:0]              cmd_r;
  logic [SEQ_W-1:0]        seq_r;
  logic [TAG_W-1:0]        tag_r;
  logic [TIME_W-1:0]       arr_r;
  logic [TIME_W-1:0]       now_r;
  logic [WINDOW_SLOTS-1:0] valid_r;
  logic [SEQ_W-1:0]        exp_r;
  logic [RW-1:0]           rs_r;
  logic [RW-1:0]           held_r;
  logic [LOST_W-1:0]       lost_r;
  logic [XW-1:0]           x_r;
  logic [XW-1:0]           q_r;
  logic [IW-1:0]           rem_r;
  logic                    cnt_r;
  logic [IW-1:0]           idx_r;
  logic                    pv_r;
  logic                    res_dlv_r;
  logic [TAG_W-1:0]        res_tag_r;
  logic [SEQ_W-1:0]        res_seq_r;
  logic                    out_valid_r;
  logic                    out_dlv_r;
  logic [TAG_W-1:0]        out_tag_r;
  logic [SEQ_W-1:0]        out_seq_r;
  logic [LOST_W-1:0]       out_lost_r;
  logic [RW-1:0]           out_held_r;

  logic [RW-1:0]     rs_w;
  logic [IW-1:0]     idx_inc;
  logic [SEQ_W:0]    dif_t;
  logic [XW-1:0]     sum_t;
  logic [XW-1:0]     x_t;
  logic [XW+MW-1:0]  prod_t;
  logic [XW-1:0]     rem_t;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [DW-1:0]     rd_data;
  logic [TIME_W-1:0] s_time;
  logic [SEQ_W-1:0]  s_seq;
  logic [TAG_W-1:0]  s_tag;
  logic [TIME_W:0]   age;
  logic              age_ok;
  logic              wr_en;

  assign rs_w    = (rs_r >= RW'(WINDOW_SLOTS)) ? '0 : rs_r;
  assign idx_inc = idx_r + IW'(1);

  // Fold the 32-bit wrap of seq - expected + read slot into a 17-bit value
  assign dif_t  = {1'b0, seq_r} - {1'b0, exp_r};
  assign sum_t  = {1'b0, dif_t[SEQ_W-1:0]} + XW'(rs_r);
  assign x_t    = !dif_t[SEQ_W] ? sum_t :
                  (sum_t[SEQ_W] ? {1'b0, sum_t[SEQ_W-1:0]} : sum_t + XW'(WRAP));
  assign prod_t = x_r * MW'(MUL);
  assign rem_t  = x_r - q_r * XW'(WINDOW_SLOTS);

  assign {s_time, s_seq, s_tag} = rd_data;
  assign age    = {1'b0, now_r} - {1'b0, s_time};
  assign age_ok = !age[TIME_W] && (age[TIME_W-1:0] >= {{(TIME_W-TMO_W){1'b0}}, timeout_r});

  assign rd_en   = cmd.rd_rs || cmd.scan_first || cmd.scan_step;
  assign rd_addr = cmd.rd_rs ? rs_w[IW-1:0] : (cmd.scan_first ? '0 : idx_inc);
  assign wr_en   = cmd.add_wr && !valid_r[rem_r];

  prw_ram #(
    .WIDTH (DW),
    .DEPTH (WINDOW_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rem_r),
    .wr_data ({arr_r, seq_r, tag_r}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_command;
      seq_r <= in_seq_number;
      tag_r <= in_packet_tag;
      arr_r <= in_arrival_time;
      now_r <= in_now_time;
    end
    if (cmd.mod_start) begin
      x_r   <= x_t;
      cnt_r <= 1'b0;
    end else if (cmd.mod_step) begin
      if (!cnt_r) begin
        q_r <= XW'(prod_t >> SH);
      end else begin
        rem_r <= rem_t[IW-1:0];
      end
      cnt_r <= 1'b1;
    end
    if (rd_en) begin
      idx_r <= rd_addr;
      pv_r  <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      exp_r     <= '0;
      rs_r      <= '0;
      held_r    <= '0;
      lost_r    <= '0;
      res_dlv_r <= 1'b0;
      res_tag_r <= '0;
      res_seq_r <= '0;
    end else begin
      if (cmd.load_in) begin
        res_dlv_r <= 1'b0;
        res_tag_r <= '0;
        res_seq_r <= '0;
      end
      if (cmd.rd_rs) rs_r <= rs_w;
      if (wr_en) begin
        valid_r[rem_r] <= 1'b1;
        held_r         <= held_r + RW'(1);
      end
      if (cmd.take) begin
        valid_r[idx_r] <= 1'b0;
        if (exp_r < s_seq) lost_r <= lost_r + LOST_W'(s_seq - exp_r);
        exp_r     <= s_seq + SEQ_W'(1);
        held_r    <= held_r - RW'(1);
        rs_r      <= RW'(idx_r) + RW'(1);
        res_dlv_r <= 1'b1;
        res_tag_r <= s_tag;
        res_seq_r <= s_seq;
      end
      if (cmd.empty_get) rs_r <= '0;
      if (cmd.slide) begin
        lost_r  <= lost_r + LOST_W'(held_r);
        valid_r <= '0;
        exp_r   <= seq_r;
        held_r  <= '0;
        rs_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_dlv_r  <= res_dlv_r;
      out_tag_r  <= res_tag_r;
      out_seq_r  <= res_seq_r;
      out_lost_r <= lost_r;
      out_held_r <= held_r;
    end
  end

  assign stat.cmd       = cmd_r;
  assign stat.mod_last  = cnt_r;
  assign stat.slot_hit  = pv_r;
  assign stat.held_zero = (held_r == '0);
  assign stat.scan_hit  = pv_r && age_ok;
  assign stat.scan_last = (idx_r == IW'(WINDOW_SLOTS - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_delivered    = out_dlv_r;
  assign out_tag          = out_tag_r;
  assign out_seq          = out_seq_r;
  assign out_lost_total   = out_lost_r;
  assign out_stored_count = out_held_r;

endmodule

[hw/rtl/packet_reorder_window.sv]
// Packet reorder window top level: streaming ports, controller and datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Reorder window for sequence-numbered packets. Each request (add, get, slide or
// no-op in in_tuser) yields exactly one result. An add reduces its slot index
// modulo WINDOW_SLOTS by a reciprocal multiplication, quotient first and then
// remainder. A get first reads the in-order slot; when that slot is empty and
// packets are held, the timeout scan reads one slot per cycle through the single
// slot memory read port. A finished result sits in the output register while
// the next request is taken; the result after it is held back until the first
// has been taken.
module packet_reorder_window #(
  parameter int unsigned WINDOW_SLOTS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [prw_pkg::TMO_W-1:0]              cfg_wr_data,  // timeout in ms
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // seq_number[15:0], packet_tag[31:16], arrival_time[63:32], now_time[95:64]
  input  logic [95:0]                            in_tdata,
  input  logic [1:0]                             in_tuser,     // command
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // out_tag[15:0], out_seq[31:16], lost_total[63:32], stored_count above, zero pad
  output logic [((64+$clog2(WINDOW_SLOTS+1)+7)/8)*8-1:0] out_tdata,
  output logic                                   out_tuser     // delivered
);
  import prw_pkg::*;

  localparam int unsigned CW = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned OW = ((64 + CW + 7) / 8) * 8;

  prw_cmd_t          cmd;
  prw_stat_t         stat;
  logic [TAG_W-1:0]  o_tag;
  logic [SEQ_W-1:0]  o_seq;
  logic [LOST_W-1:0] o_lost;
  logic [CW-1:0]     o_cnt;

  prw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  prw_datapath #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_command       (in_tuser),
    .in_seq_number    (in_tdata[15:0]),
    .in_packet_tag    (in_tdata[31:16]),
    .in_arrival_time  (in_tdata[63:32]),
    .in_now_time      (in_tdata[95:64]),
    .out_ready        (out_tready),
    .out_valid        (out_tvalid),
    .out_delivered    (out_tuser),
    .out_tag          (o_tag),
    .out_seq          (o_seq),
    .out_lost_total   (o_lost),
    .out_stored_count (o_cnt)
  );

  assign out_tdata = OW'({o_cnt, o_lost, o_seq, o_tag});

  `PRW_ASSERT(a_busy_after_req, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "request taken while busy")
  `PRW_ASSERT(a_count_bound, clk, rst_n, out_tvalid |-> (o_cnt <= CW'(WINDOW_SLOTS)), "stored count above window size")
  `PRW_ASSERT(a_no_dlv_zero, clk, rst_n, (out_tvalid && !out_tuser) |-> (o_tag == '0 && o_seq == '0), "packet fields set without delivery")
  `PRW_ASSERT_ALWAYS(a_take_one, clk, $onehot0({cmd.take, cmd.slide, cmd.add_wr, cmd.empty_get}), "conflicting window updates")

endmodule
